FILE: hw/rtl/quadratic_root_solver_defines.svh
// assertion macros for the quadratic root solver
// used by the top level only, no other dependencies
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// implication checked on every clock, disabled during reset
`define QRS_ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define QRS_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: hw/rtl/qrs_pkg.sv
// shared types and constants for the quadratic root solver
// no dependencies
`default_nettype none
package qrs_pkg;
	localparam int unsigned KIND_W = 3;
	localparam int unsigned FIELD_W = 32;

	typedef enum logic [KIND_W-1:0] {
		KIND_INVALID    = 3'd0,
		KIND_IMPOSSIBLE = 3'd1,
		KIND_SINGLE     = 3'd2,
		KIND_REAL_PAIR  = 3'd3,
		KIND_COMPLEX    = 3'd4
	} kind_t;
endpackage
`default_nettype wire

FILE: hw/rtl/qrs_sqrt_cell.sv
// one restoring square root step, one result bit per cell
// no package dependencies
`default_nettype none
module qrs_sqrt_cell #(
	parameter int unsigned RAD_W = 68,
	parameter int unsigned ROOT_W = 34,
	parameter int unsigned BIT_IDX = 0
) (
	input  wire logic              clk,
	input  wire logic [RAD_W-1:0]  rem_in,
	input  wire logic [ROOT_W-1:0] root_in,
	output logic      [RAD_W-1:0]  rem_out,
	output logic      [ROOT_W-1:0] root_out
);
	logic [RAD_W+1:0] trial;
	logic [RAD_W+1:0] rem_w;

	// trial subtraction: (2*root + bit) * bit weight
	always_comb begin
		trial = ({{(RAD_W+2-ROOT_W){1'b0}}, root_in} << (BIT_IDX + 1))
			+ ((RAD_W+2)'(1) << (2 * BIT_IDX));
		rem_w = {2'b00, rem_in};
	end

	always_ff @(posedge clk) begin
		if (rem_w >= trial) begin
			rem_out  <= RAD_W'(rem_w - trial);
			root_out <= root_in | (ROOT_W'(1) << BIT_IDX);
		end else begin
			rem_out  <= rem_in;
			root_out <= root_in;
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/qrs_div_cell.sv
// one restoring division step for one unsigned quotient
// no package dependencies
`default_nettype none
module qrs_div_cell #(
	parameter int unsigned NUM_W = 48,
	parameter int unsigned DEN_W = 33,
	parameter int unsigned BIT_IDX = 0
) (
	input  wire logic             clk,
	input  wire logic [DEN_W-1:0] den,
	input  wire logic [NUM_W-1:0] rem_in,
	input  wire logic [NUM_W-1:0] quo_in,
	output logic      [NUM_W-1:0] rem_out,
	output logic      [NUM_W-1:0] quo_out
);
	logic [NUM_W+DEN_W-1:0] shifted_den;
	logic [NUM_W+DEN_W-1:0] rem_w;

	always_comb begin
		shifted_den = {{NUM_W{1'b0}}, den} << BIT_IDX;
		rem_w = {{DEN_W{1'b0}}, rem_in};
	end

	always_ff @(posedge clk) begin
		if (rem_w >= shifted_den) begin
			rem_out <= NUM_W'(rem_w - shifted_den);
			quo_out <= quo_in | (NUM_W'(1) << BIT_IDX);
		end else begin
			rem_out <= rem_in;
			quo_out <= quo_in;
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/quadratic_root_solver.sv
// Quadratic root solver: one coefficient word in, one solution word out.
// Channels: in (coef_a, coef_b, coef_c) and out (case_kind, first_value,
// second_value, saturated), each with valid and ready.
// Stages: three front stages, a chain of one-bit square root cells (one per
// root bit), a chain of one-bit divider cells (one per quotient bit), then
// clamp into the output register.
// Throughput: one word per cycle. The whole pipeline advances only when the
// output register is empty or being taken, so a stalled receiver freezes
// every stage and in_ready falls; nothing is dropped.
// Reset clears all stage valid bits; the pipeline then accepts at once.
// Divisions are exact with truncation toward zero; results are clamped to
// the signed WORD_BITS range and then cut to 32 bits, with saturated set
// on any clamp.
`default_nettype none
`include "quadratic_root_solver_defines.svh"
module quadratic_root_solver #(
	parameter int unsigned FRAC_BITS = 16,
	parameter int unsigned WORD_BITS = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [qrs_pkg::FIELD_W-1:0] coef_a,
	input  wire logic signed [qrs_pkg::FIELD_W-1:0] coef_b,
	input  wire logic signed [qrs_pkg::FIELD_W-1:0] coef_c,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [qrs_pkg::KIND_W-1:0]              case_kind,
	output logic signed [qrs_pkg::FIELD_W-1:0]      first_value,
	output logic signed [qrs_pkg::FIELD_W-1:0]      second_value,
	output logic                                    saturated
);
	localparam int unsigned FW = qrs_pkg::FIELD_W;
	// discriminant magnitude width and root width
	localparam int unsigned RAD_W = 2 * FW + 4;
	localparam int unsigned ROOT_W = RAD_W / 2;
	// numerators: magnitude << FRAC_BITS
	localparam int unsigned NUM_W = ROOT_W + FRAC_BITS;
	localparam int unsigned DEN_W = FW + 1;
	localparam int unsigned VAL_W = NUM_W + 2;
	localparam int unsigned PRE_ST = 3;
	localparam int unsigned N_ST = PRE_ST + ROOT_W + NUM_W;

	typedef struct packed {
		logic                     kind_hi;   // a nonzero
		logic [qrs_pkg::KIND_W-1:0] kind;
		logic                     neg1;      // sign of p1 / single quotient
		logic                     neg2;      // sign of p2
		logic [DEN_W-1:0]         den;
	} side_t;

	logic advance;
	logic [N_ST-1:0] vld;
	side_t side_s [N_ST-1:1];

	// whole pipeline moves together
	assign advance  = !out_valid || out_ready;
	assign in_ready = advance;

	// divisor: |b| for the single root, 2|a| otherwise
	function automatic logic [DEN_W-1:0] a0_mux_den(input logic az,
		input logic [FW-1:0] mbv, input logic [FW-1:0] mav);
		a0_mux_den = az ? {1'b0, mbv} : {mav, 1'b0};
	endfunction

	// stage 1: magnitudes and products
	logic [FW-1:0] ma, mb, mc;
	assign ma = coef_a[FW-1] ? FW'(-coef_a) : coef_a;
	assign mb = coef_b[FW-1] ? FW'(-coef_b) : coef_b;
	assign mc = coef_c[FW-1] ? FW'(-coef_c) : coef_c;

	logic [2*FW-1:0]  bb_s1, ac_s1;
	logic [FW-1:0]    mb_s1, mc_s1;
	logic [DEN_W-1:0] den_s1;
	logic             a0_s1, b0_s1, c0_s1, an_s1, bn_s1, cn_s1;
	always_ff @(posedge clk) begin
		if (advance) begin
			bb_s1 <= mb * mb;
			ac_s1 <= ma * mc;
			mb_s1 <= mb;
			mc_s1 <= mc;
			a0_s1 <= coef_a == '0;
			b0_s1 <= coef_b == '0;
			c0_s1 <= coef_c == '0;
			an_s1 <= coef_a[FW-1];
			bn_s1 <= coef_b[FW-1];
			cn_s1 <= coef_c[FW-1];
			den_s1 <= a0_mux_den(coef_a == '0, mb, ma);
		end
	end

	// stage 2: discriminant magnitude and sign, initial kind and quotient signs
	logic [RAD_W-1:0] d_s2;
	logic             dneg_s2;
	logic [FW-1:0]    mb_s2, mc_s2;
	logic [RAD_W:0]   b2w, a4w;
	assign b2w = (RAD_W+1)'(bb_s1);
	assign a4w = (RAD_W+1)'(ac_s1) << 2;
	always_ff @(posedge clk) begin
		if (advance) begin
			mb_s2 <= mb_s1;
			mc_s2 <= mc_s1;
			if ((an_s1 != cn_s1) && !c0_s1) begin
				d_s2 <= RAD_W'(b2w + a4w);
				dneg_s2 <= 1'b0;
			end else if (a4w > b2w) begin
				d_s2 <= RAD_W'(a4w - b2w);
				dneg_s2 <= 1'b1;
			end else begin
				d_s2 <= RAD_W'(b2w - a4w);
				dneg_s2 <= 1'b0;
			end
			side_s[1].den <= den_s1;
			if (a0_s1) begin
				side_s[1].kind_hi <= 1'b0;
				side_s[1].kind <= b0_s1 ? (c0_s1 ? qrs_pkg::KIND_INVALID
					: qrs_pkg::KIND_IMPOSSIBLE) : qrs_pkg::KIND_SINGLE;
				// -c/b negative when c and b have the same sign
				side_s[1].neg1 <= !c0_s1 && (cn_s1 == bn_s1);
				side_s[1].neg2 <= 1'b0;
			end else begin
				side_s[1].kind_hi <= 1'b1;
				side_s[1].kind <= qrs_pkg::KIND_REAL_PAIR;
				// -b/(2a) negative when b and a have the same sign
				side_s[1].neg1 <= !b0_s1 && (bn_s1 == an_s1);
				side_s[1].neg2 <= an_s1;
			end
		end
	end

	// square root chain; first numerator rides alongside
	logic [RAD_W-1:0]  srem [ROOT_W:0];
	logic [ROOT_W-1:0] sroot [ROOT_W:0];
	logic [FW-1:0]     n1_q [ROOT_W:0];

	// stage 3: fix kind on discriminant sign
	logic [RAD_W-1:0] d_s3;
	always_ff @(posedge clk) begin
		if (advance) begin
			d_s3 <= d_s2;
			n1_q[0] <= side_s[1].kind_hi ? mb_s2 : mc_s2;
			side_s[2].kind_hi <= side_s[1].kind_hi;
			side_s[2].kind <= (side_s[1].kind_hi && dneg_s2) ? qrs_pkg::KIND_COMPLEX
				: side_s[1].kind;
			side_s[2].neg1 <= side_s[1].neg1;
			side_s[2].neg2 <= side_s[1].neg2;
			side_s[2].den <= side_s[1].den;
		end
	end

	assign srem[0] = d_s3;
	assign sroot[0] = '0;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
		logic [RAD_W-1:0]  rem_o;
		logic [ROOT_W-1:0] root_o;
		qrs_sqrt_cell #(.RAD_W(RAD_W), .ROOT_W(ROOT_W), .BIT_IDX(ROOT_W-1-i)) u_cell (
			.clk(clk), .rem_in(srem[i]), .root_in(sroot[i]),
			.rem_out(rem_o), .root_out(root_o)
		);
		// hold registers keep each cell's output while the pipeline stalls
		logic [RAD_W-1:0]  rem_hold_q;
		logic [ROOT_W-1:0] root_hold_q;
		logic              adv_q;
		always_ff @(posedge clk) begin
			adv_q <= advance;
			if (adv_q) begin
				rem_hold_q <= rem_o;
				root_hold_q <= root_o;
			end
			if (advance) begin
				n1_q[i+1] <= n1_q[i];
				side_s[PRE_ST+i] <= side_s[PRE_ST+i-1];
			end
		end
		assign srem[i+1]  = adv_q ? rem_o : rem_hold_q;
		assign sroot[i+1] = adv_q ? root_o : root_hold_q;
	end

	// division chain: two quotients share one divisor
	logic [NUM_W-1:0] r1 [NUM_W:0], q1 [NUM_W:0], r2 [NUM_W:0], q2 [NUM_W:0];
	assign r1[0] = NUM_W'(n1_q[ROOT_W]) << FRAC_BITS;
	assign r2[0] = NUM_W'(sroot[ROOT_W]) << FRAC_BITS;
	assign q1[0] = '0;
	assign q2[0] = '0;

	for (genvar j = 0; j < NUM_W; j++) begin : g_div
		localparam int unsigned SI = PRE_ST + ROOT_W + j;
		logic [NUM_W-1:0] r1_o, q1_o, r2_o, q2_o;
		logic [NUM_W-1:0] r1_hold_q, q1_hold_q, r2_hold_q, q2_hold_q;
		logic             adv_q;
		qrs_div_cell #(.NUM_W(NUM_W), .DEN_W(DEN_W), .BIT_IDX(NUM_W-1-j)) u_c1 (
			.clk(clk), .den(side_s[SI-1].den), .rem_in(r1[j]), .quo_in(q1[j]),
			.rem_out(r1_o), .quo_out(q1_o)
		);
		qrs_div_cell #(.NUM_W(NUM_W), .DEN_W(DEN_W), .BIT_IDX(NUM_W-1-j)) u_c2 (
			.clk(clk), .den(side_s[SI-1].den), .rem_in(r2[j]), .quo_in(q2[j]),
			.rem_out(r2_o), .quo_out(q2_o)
		);
		always_ff @(posedge clk) begin
			adv_q <= advance;
			if (adv_q) begin
				r1_hold_q <= r1_o; q1_hold_q <= q1_o;
				r2_hold_q <= r2_o; q2_hold_q <= q2_o;
			end
			if (advance) begin
				side_s[SI] <= side_s[SI-1];
			end
		end
		assign r1[j+1] = adv_q ? r1_o : r1_hold_q;
		assign q1[j+1] = adv_q ? q1_o : q1_hold_q;
		assign r2[j+1] = adv_q ? r2_o : r2_hold_q;
		assign q2[j+1] = adv_q ? q2_o : q2_hold_q;
	end

	// valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (advance) begin
			vld <= {vld[N_ST-2:0], in_valid};
		end
	end

	// final: signs, sum and difference (real pair), clamp
	side_t sf;
	logic signed [VAL_W-1:0] p1, p2, v1, v2;
	logic signed [VAL_W-1:0] hi_lim, lo_lim;
	logic signed [VAL_W-1:0] c1, c2;
	logic s1, s2;
	logic [qrs_pkg::KIND_W-1:0] kf;
	assign sf = side_s[N_ST-1];
	assign hi_lim = (VAL_W'(1) <<< (WORD_BITS - 1)) - VAL_W'(1);
	assign lo_lim = -hi_lim - VAL_W'(1);

	always_comb begin
		p1 = sf.neg1 ? -$signed({2'b00, q1[NUM_W]}) : $signed({2'b00, q1[NUM_W]});
		p2 = sf.neg2 ? -$signed({2'b00, q2[NUM_W]}) : $signed({2'b00, q2[NUM_W]});
		kf = sf.kind;
		v1 = '0;
		v2 = '0;
		case (kf)
			qrs_pkg::KIND_SINGLE: begin
				v1 = p1;
			end
			qrs_pkg::KIND_REAL_PAIR: begin
				v1 = p1 + p2;
				v2 = p1 - p2;
			end
			qrs_pkg::KIND_COMPLEX: begin
				v1 = p1;
				v2 = p2;
			end
			default: begin
				v1 = '0;
			end
		endcase
		s1 = (v1 > hi_lim) || (v1 < lo_lim);
		s2 = (v2 > hi_lim) || (v2 < lo_lim);
		c1 = (v1 > hi_lim) ? hi_lim : ((v1 < lo_lim) ? lo_lim : v1);
		c2 = (v2 > hi_lim) ? hi_lim : ((v2 < lo_lim) ? lo_lim : v2);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= vld[N_ST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			case_kind <= kf;
			first_value <= FW'(c1);
			second_value <= FW'(c2);
			saturated <= s1 || s2;
		end
	end

	// checks
	`QRS_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(first_value),
		"output word changed under stall")
	`QRS_ASSERT_IMP(a_ready, out_valid && !out_ready, !in_ready,
		"input taken while output stalled")
	`QRS_ASSERT_IMP(a_kind, out_valid && (case_kind == qrs_pkg::KIND_INVALID
		|| case_kind == qrs_pkg::KIND_IMPOSSIBLE), first_value == '0 && !saturated,
		"nonzero value for degenerate equation")
endmodule
`default_nettype wire
